// ===== hdl/hsc_pkg.sv =====
// Shared types, constants and jamo pair tables for the Hangul syllable composer.
// No dependencies; imported by hsc_compose and hangul_syllable_composer_core.
package hsc_pkg;

  // Composition phases; the two end phases are transition targets only, never held
  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_INITIAL = 3'd1,
    PH_MEDIAL  = 3'd2,
    PH_DMEDIAL = 3'd3,
    PH_FINAL   = 3'd4,
    PH_DFINAL  = 3'd5,
    PH_END1    = 3'd6,
    PH_END2    = 3'd7
  } phase_t;

  localparam logic [15:0] FILL_CODE        = 16'h8441;
  localparam logic [15:0] INIT_SEED_CODE   = 16'h8041;
  localparam logic [15:0] MEDIAL_SEED_CODE = 16'h8401;
  localparam logic [4:0]  FILL_FINAL       = 5'd1;

  localparam logic [7:0] CONS_BASE  = 8'h80;
  localparam logic [7:0] VOWEL_BASE = 8'hA0;
  localparam logic [7:0] FINAL_BASE = 8'hC0;
  localparam logic [7:0] CONS_LO    = 8'h82;
  localparam logic [7:0] CONS_HI    = 8'h94;
  localparam logic [7:0] VOWEL_LO   = 8'hA3;
  localparam logic [7:0] VOWEL_HI   = 8'hBD;
  localparam logic [7:0] INIT_LIMIT = 8'h88;
  localparam logic [7:0] NO_FINAL   = 8'hC1;
  localparam logic [7:0] NO_PAIR    = 8'h00;

  // Consonants that can never close a syllable
  localparam logic [7:0] KEY_DD = 8'h86;
  localparam logic [7:0] KEY_BB = 8'h8A;
  localparam logic [7:0] KEY_JJ = 8'h8F;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] code;
    logic [7:0]  last_key;
    logic [7:0]  prev_key;
  } hsc_state_t;

  typedef struct packed {
    logic        flushed;
    logic [15:0] flushed_code;
    logic [15:0] compose_code;
    logic [2:0]  compose_phase;
    logic        bad_key;
  } hsc_result_t;

  function automatic logic [7:0] vowel_pair(input logic [7:0] first, input logic [7:0] second);
    logic [7:0] r;
    case ({first, second})
      16'hADA3: r = 8'hAE;
      16'hADA4: r = 8'hAF;
      16'hADBD: r = 8'hB2;
      16'hB4A7: r = 8'hB5;
      16'hB4AA: r = 8'hB6;
      16'hB4BD: r = 8'hB7;
      16'hBBBD: r = 8'hBC;
      default:  r = NO_PAIR;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] final_pair(input logic [7:0] first, input logic [7:0] second);
    logic [7:0] r;
    case ({first, second})
      16'h828B: r = 8'hC4;
      16'h848E: r = 8'hC6;
      16'h8494: r = 8'hC7;
      16'h8782: r = 8'hCA;
      16'h8788: r = 8'hCB;
      16'h8789: r = 8'hCC;
      16'h878B: r = 8'hCD;
      16'h8792: r = 8'hCE;
      16'h8793: r = 8'hCF;
      16'h8794: r = 8'hD0;
      16'h898B: r = 8'hD4;
      default:  r = NO_PAIR;
    endcase
    return r;
  endfunction

  // Initial consonant slot to final slot; codes outside the consonant range map to the fill final
  function automatic logic [7:0] final_of(input logic [7:0] cons);
    logic [7:0] r;
    case (cons)
      8'h82:   r = 8'hC2;
      8'h83:   r = 8'hC3;
      8'h84:   r = 8'hC5;
      8'h85:   r = 8'hC8;
      8'h86:   r = 8'h00;
      8'h87:   r = 8'hC9;
      8'h88:   r = 8'hD1;
      8'h89:   r = 8'hD3;
      8'h8A:   r = 8'h00;
      8'h8B:   r = 8'hD5;
      8'h8C:   r = 8'hD6;
      8'h8D:   r = 8'hD7;
      8'h8E:   r = 8'hD8;
      8'h8F:   r = 8'h00;
      8'h90:   r = 8'hD9;
      8'h91:   r = 8'hDA;
      8'h92:   r = 8'hDB;
      8'h93:   r = 8'hDC;
      8'h94:   r = 8'hDD;
      default: r = NO_FINAL;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/hangul_syllable_composer_core.sv =====
// Two-set Hangul syllable composer: one jamo key per transaction, one result per key.
// A key passes through the input register, then the composer into the result register.
// Throughput: one key per cycle unless out_stall blocks; the state loops through hsc_compose.
// Reset: synchronous, clears the phase to start, loads the fill syllable, empties both registers.
// Depends on hsc_pkg and hsc_compose.
module hangul_syllable_composer_core import hsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // key channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  key_code,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        flushed,
  output logic [15:0] flushed_code,
  output logic [15:0] compose_code,
  output logic [2:0]  compose_phase,
  output logic        bad_key
);

  // Input register: one key waiting to be composed
  logic        hold_valid;
  logic [7:0]  hold_key;

  // Syllable under composition and the last two keys of it
  hsc_state_t  state;
  hsc_state_t  state_next;

  // Result register
  hsc_result_t result;
  hsc_result_t result_next;

  logic        out_free;
  logic        advance;
  logic        in_take;

  // The result register is free when empty or being drained this cycle
  assign out_free = !out_valid || !out_stall;
  // Move the held key through the composer into the result register
  assign advance  = hold_valid && out_free;
  // Stall only while the held key cannot move on
  assign in_stall = hold_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  hsc_compose u_compose (
    .cur (state),
    .key (hold_key),
    .nxt (state_next),
    .res (result_next)
  );

  // Input register: load on every accepted transaction, clear once the key has moved on
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_take) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_key <= key_code;
    end
  end

  // Syllable state: advance together with the result, hold otherwise.
  // Key history carries no reset; it is read only after being written.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase <= PH_START;
      state.code  <= FILL_CODE;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register: fill on advance, drop once the transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign flushed       = result.flushed;
  assign flushed_code  = result.flushed_code;
  assign compose_code  = result.compose_code;
  assign compose_phase = result.compose_phase;
  assign bad_key       = result.bad_key;

endmodule

// ===== hdl/hsc_compose.sv =====
// Single-pass composition step: current syllable state and one key in, next state and result out.
// Depends on hsc_pkg.
module hsc_compose import hsc_pkg::*; (
  input  hsc_state_t  cur,
  input  logic [7:0]  key,
  output hsc_state_t  nxt,
  output hsc_result_t res
);

  logic        is_vowel;
  logic        is_cons;
  logic        is_bad;
  logic        can_final;
  logic [15:0] base_code;
  logic [7:0]  old_key;
  logic [7:0]  vpair;
  logic [7:0]  fpair;
  logic        init_empty;
  phase_t      target;

  assign is_vowel   = (key >= VOWEL_LO) && (key <= VOWEL_HI);
  assign is_cons    = (key >= CONS_LO) && (key <= CONS_HI);
  assign is_bad     = !is_vowel && !is_cons;
  assign can_final  = is_cons && (key != KEY_DD) && (key != KEY_BB) && (key != KEY_JJ);
  assign base_code  = (cur.phase != PH_START) ? cur.code : FILL_CODE;
  assign old_key    = (cur.phase != PH_START) ? cur.last_key : 8'h00;
  assign vpair      = vowel_pair(old_key, key);
  assign fpair      = final_pair(old_key, key);
  assign init_empty = base_code[15:8] < INIT_LIMIT;

  // Next phase
  always_comb begin
    unique case (cur.phase)
      PH_START:   target = is_cons ? PH_INITIAL : PH_MEDIAL;
      PH_INITIAL: target = is_vowel ? PH_MEDIAL : PH_END1;
      PH_MEDIAL: begin
        if (can_final) begin
          target = init_empty ? PH_END1 : PH_FINAL;
        end else if (is_vowel && (vpair != NO_PAIR)) begin
          target = PH_DMEDIAL;
        end else begin
          target = PH_END1;
        end
      end
      PH_DMEDIAL: begin
        if (can_final) begin
          target = init_empty ? PH_END1 : PH_FINAL;
        end else begin
          target = PH_END1;
        end
      end
      PH_FINAL: begin
        if (is_cons && (fpair != NO_PAIR)) begin
          target = PH_DFINAL;
        end else begin
          target = is_vowel ? PH_END2 : PH_END1;
        end
      end
      PH_DFINAL, PH_END1, PH_END2: target = is_vowel ? PH_END2 : PH_END1;
    endcase
  end

  // Next syllable state and result
  always_comb begin
    nxt          = cur;
    nxt.phase    = target;
    nxt.code     = base_code;
    nxt.prev_key = cur.last_key;
    nxt.last_key = key;
    res.flushed      = 1'b0;
    res.flushed_code = 16'h0000;
    res.bad_key      = 1'b0;

    unique case (target)
      PH_START: begin
        nxt.code = base_code;
      end
      PH_INITIAL: begin
        nxt.code = {base_code[15], 5'(key - CONS_BASE), base_code[9:0]};
      end
      PH_MEDIAL: begin
        nxt.code = {base_code[15:10], 5'(key - VOWEL_BASE), base_code[4:0]};
      end
      PH_DMEDIAL: begin
        nxt.code = {base_code[15:10], 5'(vpair - VOWEL_BASE), base_code[4:0]};
      end
      PH_FINAL: begin
        nxt.code = {base_code[15:5], 5'(final_of(key) - FINAL_BASE)};
      end
      PH_DFINAL: begin
        nxt.code = {base_code[15:5], 5'(fpair - FINAL_BASE)};
      end
      PH_END1: begin
        res.flushed      = 1'b1;
        res.flushed_code = base_code;
        if (is_cons) begin
          nxt.phase = PH_INITIAL;
          nxt.code  = {INIT_SEED_CODE[15], 5'(key - CONS_BASE), INIT_SEED_CODE[9:0]};
        end else begin
          nxt.phase = PH_MEDIAL;
          nxt.code  = {MEDIAL_SEED_CODE[15:10], 5'(key - VOWEL_BASE), MEDIAL_SEED_CODE[4:0]};
        end
      end
      PH_END2: begin
        // Keep a compound final's first half, else fill the final; the last consonant moves on
        res.flushed = 1'b1;
        if (cur.phase == PH_DFINAL) begin
          res.flushed_code = {base_code[15:5], 5'(final_of(cur.prev_key) - FINAL_BASE)};
        end else begin
          res.flushed_code = {base_code[15:5], FILL_FINAL};
        end
        nxt.phase = PH_MEDIAL;
        nxt.code  = {INIT_SEED_CODE[15], 5'(old_key - CONS_BASE), 5'(key - VOWEL_BASE),
                     INIT_SEED_CODE[4:0]};
      end
    endcase

    if (is_bad) begin
      nxt              = cur;
      res.flushed      = 1'b0;
      res.flushed_code = 16'h0000;
      res.bad_key      = 1'b1;
    end

    res.compose_code  = nxt.code;
    res.compose_phase = nxt.phase;
  end

endmodule
